[sv/tbsg_pkg.sv]
package tbsg_pkg;

  // field widths fixed by the item formats
  localparam int KIND_W  = 2;
  localparam int SPACE_W = 16;
  localparam int SAMP_W  = 24;
  localparam int PLEN_W  = 16;
  localparam int PROD_W  = 25;
  localparam int BYTE_W  = 8;

  // default burst counter width
  localparam int COUNT_W_DEF = 24;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [SAMP_W-1:0] SAMP_RST = SAMP_W'(1000);
  localparam logic [PLEN_W-1:0] PLEN_RST = PLEN_W'(64);

  // divider: one quotient bit per step over the remaining sample count
  localparam int DIV_STEPS = SAMP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DONE = 2'd1,
    PH_RUN  = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    REQ_OUTPUT  = 2'd0,
    REQ_SWITCH  = 2'd1,
    REQ_STOP    = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic {
    REG_BURST = 1'b0,
    REG_PLEN  = 1'b1
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic load_final;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

[sv/tbsg_if.sv]
// request channel
interface tbsg_req_if import tbsg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  req_type;
  logic [SPACE_W-1:0] space;

  modport source (output valid, output req_type, output space, input ready);
  modport sink   (input valid, input req_type, input space, output ready);
endinterface

// result channel
interface tbsg_res_if import tbsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROD_W-1:0] produced;
  logic              start_of_burst;
  logic              end_of_burst;
  logic [BYTE_W-1:0] first_byte;
  logic              msg_error;

  modport source (output valid, output produced, output start_of_burst,
                  output end_of_burst, output first_byte, output msg_error,
                  input ready);
  modport sink   (input valid, input produced, input start_of_burst,
                  input end_of_burst, input first_byte, input msg_error,
                  output ready);
endinterface

[sv/tbsg_regs.sv]
module tbsg_regs import tbsg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              reg_sel,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [SAMP_W-1:0] burst_samples,
  output logic [PLEN_W-1:0] packet_length
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_samples <= SAMP_RST;
      packet_length <= PLEN_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(reg_sel))
        REG_BURST: burst_samples <= pwdata[SAMP_W-1:0];
        REG_PLEN:  packet_length <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx_t'(reg_sel))
      REG_BURST: prdata = APB_DW'(burst_samples);
      REG_PLEN:  prdata = APB_DW'(packet_length);
      default:   prdata = '0;
    endcase
  end

endmodule

[sv/tbsg_ctrl.sv]
module tbsg_ctrl import tbsg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready && stat.need_div) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.load_final = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = stat.out_free;
        cmd.take = in_valid && stat.out_free;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FIN: begin
        cmd.load_final = stat.out_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.take && stat.need_div |=> state == ST_DIV)
    else $error("final chunk did not start the divider");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("word taken while divider busy");

  a_fin_return: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && stat.out_free |=> state == ST_IDLE)
    else $error("padded result not handed over");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && stat.div_last |=> state == ST_FIN)
    else $error("divider overran its step count");
`endif

endmodule

[sv/tbsg_dp.sv]
module tbsg_dp import tbsg_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [SAMP_W-1:0]  burst_samples,
  input  logic [PLEN_W-1:0]  packet_length,
  input  logic [KIND_W-1:0]  req_type,
  input  logic [SPACE_W-1:0] space,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [PROD_W-1:0]  produced,
  output logic               start_of_burst,
  output logic               end_of_burst,
  output logic [BYTE_W-1:0]  first_byte,
  output logic               msg_error
);

  localparam int SUM_W = ((COUNT_WIDTH > SAMP_W) ? COUNT_WIDTH : SAMP_W) + 1;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] burst_count, burst_count_next;
  logic [BYTE_W-1:0]      byte_value;

  // divider state
  logic [SAMP_W-1:0]    rem_q;
  logic [SAMP_W-1:0]    dq;
  logic [PLEN_W:0]      part;
  logic [PLEN_W:0]      trial;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 sob_q;

  req_kind_t         kind;
  logic [SUM_W-1:0]  sum, total_x, count_x;
  logic [SAMP_W-1:0] rem;
  logic              is_final, running, stopping, sob_now, need_div, load;

  logic [PROD_W-1:0] imm_prod, fin_prod, sel_prod;
  logic              imm_sob, imm_eob, imm_err;
  logic [BYTE_W-1:0] imm_first;

  // burst arithmetic
  assign kind     = req_kind_t'(req_type);
  assign count_x  = SUM_W'(burst_count);
  assign total_x  = SUM_W'(burst_samples);
  assign sum      = count_x + SUM_W'(space);
  assign is_final = sum >= total_x;
  assign rem      = (count_x < total_x) ? SAMP_W'(total_x - count_x) : '0;
  assign running  = phase == PH_RUN;
  assign stopping = phase == PH_STOP;
  assign sob_now  = burst_count == '0;
  assign need_div = (kind == REQ_OUTPUT) && running && is_final && (packet_length != '0);

  assign stat.need_div = need_div;
  assign stat.div_last = div_cnt == '0;
  assign stat.out_free = !out_valid || out_ready;

  // result of a word that completes at once
  always_comb begin
    imm_prod  = '0;
    imm_sob   = 1'b0;
    imm_eob   = 1'b0;
    imm_err   = 1'b0;
    imm_first = '0;
    case (kind)
      REQ_UNKNOWN: imm_err = 1'b1;
      REQ_OUTPUT: begin
        if (stopping) begin
          imm_prod  = PROD_W'(packet_length);
          imm_eob   = 1'b1;
          imm_first = byte_value;
        end else if (running) begin
          imm_first = byte_value;
          imm_sob   = sob_now;
          if (is_final) begin
            // zero packet length: no padding
            imm_prod = PROD_W'(rem);
            imm_eob  = 1'b1;
          end else begin
            imm_prod = PROD_W'(space);
          end
        end
      end
      default: ;
    endcase
  end

  // gate phase and count
  always_comb begin
    phase_next       = phase;
    burst_count_next = burst_count;
    case (kind)
      REQ_SWITCH: begin
        if (phase == PH_IDLE) begin
          phase_next = PH_RUN;
        end else if (phase == PH_DONE) begin
          phase_next = PH_IDLE;
        end
      end
      REQ_STOP: begin
        if (running) begin
          phase_next = PH_STOP;
        end
      end
      REQ_OUTPUT: begin
        if (stopping || (running && is_final)) begin
          phase_next       = PH_DONE;
          burst_count_next = '0;
        end else if (running) begin
          burst_count_next = sum[COUNT_WIDTH-1:0];
        end
      end
      default: ;
    endcase
  end

  // padded length: remaining count up to next packet boundary
  assign fin_prod = PROD_W'(rem_q) + PROD_W'(packet_length) - PROD_W'(part[PLEN_W-1:0]);
  assign load     = (cmd.take && !need_div) || cmd.load_final;
  assign sel_prod = cmd.load_final ? fin_prod : imm_prod;
  assign trial    = {part[PLEN_W-1:0], dq[SAMP_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      burst_count <= '0;
      byte_value  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.take) begin
        phase       <= phase_next;
        burst_count <= burst_count_next;
      end
      if (load) begin
        byte_value <= byte_value + sel_prod[BYTE_W-1:0];
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      produced <= sel_prod;
      if (cmd.load_final) begin
        start_of_burst <= sob_q;
        end_of_burst   <= 1'b1;
        first_byte     <= byte_value;
        msg_error      <= 1'b0;
      end else begin
        start_of_burst <= imm_sob;
        end_of_burst   <= imm_eob;
        first_byte     <= imm_first;
        msg_error      <= imm_err;
      end
    end
  end

  // restoring divider, remaining count mod packet length
  always_ff @(posedge clk) begin
    if (cmd.take && need_div) begin
      rem_q   <= rem;
      dq      <= rem;
      part    <= '0;
      div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
      sob_q   <= sob_now;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, packet_length}) begin
        part <= trial - {1'b0, packet_length};
      end else begin
        part <= trial;
      end
      dq      <= dq << 1;
      div_cnt <= div_cnt - 1'b1;
    end
  end

endmodule

[sv/tdd_burst_source_gate.sv]
// Channel  | Dir | Handshake      | Payload
// req      | in  | valid / ready  | req_type, space
// res      | out | valid / ready  | produced, start_of_burst, end_of_burst,
//          |     |                | first_byte, msg_error
// cfg      | in  | APB psel/pen.  | burst_samples @0x0, packet_length @0x4
//
// One result word per request word, registered. A final chunk with a non-zero
// packet length first passes through the 24-step restoring divider for the
// padding. A new word is taken while the divider is idle and the result
// register is free or being emptied.
// rst is synchronous: gate idle, count and byte counter cleared, registers
// back to 1000 samples and 64-byte packets.
module tdd_burst_source_gate import tbsg_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic              clk,
  input  logic              rst,
  tbsg_req_if.sink          req,
  tbsg_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [SAMP_W-1:0] burst_samples;
  logic [PLEN_W-1:0] packet_length;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // configuration registers
  tbsg_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .reg_sel       (paddr[2]),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .burst_samples (burst_samples),
    .packet_length (packet_length)
  );

  // sequencer
  tbsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // gate, counters, divider, result register
  tbsg_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .burst_samples  (burst_samples),
    .packet_length  (packet_length),
    .req_type       (req.req_type),
    .space          (req.space),
    .out_ready      (res.ready),
    .out_valid      (res.valid),
    .produced       (res.produced),
    .start_of_burst (res.start_of_burst),
    .end_of_burst   (res.end_of_burst),
    .first_byte     (res.first_byte),
    .msg_error      (res.msg_error)
  );

endmodule

[tb/sv/tbsg_chunk_checker.sv]
// Watches the request, result and register ports, predicts each result word
// and compares it with what the block returns.
module tbsg_chunk_checker import tbsg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tbsg_req_if               req,
  tbsg_res_if               res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PROD_W-1:0] produced;
    logic              sob;
    logic              eob;
    logic [BYTE_W-1:0] first;
    logic              err;
  } chunk_t;

  // chunks predicted but not yet returned, oldest first
  chunk_t chunks_due[$];

  // own copy of the registers and gate state
  logic [SAMP_W-1:0]      total_samples;
  logic [PLEN_W-1:0]      pkt_len;
  phase_t                 gate;
  logic [COUNT_W_DEF-1:0] burst_cnt;
  logic [BYTE_W-1:0]      next_byte;

  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // advances the gate for one request word and returns the chunk it emits
  function automatic chunk_t next_chunk(req_kind_t kind, logic [SPACE_W-1:0] space);
    chunk_t          c;
    longint unsigned len;
    longint unsigned rem;
    longint unsigned sum;
    c = '{default: '0};
    len = 0;
    case (kind)
      REQ_SWITCH: begin
        if (gate == PH_IDLE) gate = PH_RUN;
        else if (gate == PH_DONE) gate = PH_IDLE;
      end
      REQ_STOP: begin
        if (gate == PH_RUN) gate = PH_STOP;
      end
      REQ_UNKNOWN: c.err = 1'b1;
      default: begin
        if (gate == PH_RUN || gate == PH_STOP) begin
          if (gate == PH_STOP) begin
            // stop chunk: one packet, ends the burst
            len = 64'(pkt_len);
            gate = PH_DONE;
            burst_cnt = '0;
          end else begin
            len = 64'(space);
            c.sob = (burst_cnt == '0);
            sum = 64'(burst_cnt) + 64'(space);
            if (sum >= 64'(total_samples)) begin
              // final chunk: remainder padded up, full packet when aligned
              rem = (64'(burst_cnt) < 64'(total_samples)) ?
                    64'(total_samples) - 64'(burst_cnt) : 64'd0;
              len = (pkt_len == '0) ? rem : rem + (64'(pkt_len) - rem % 64'(pkt_len));
              gate = PH_DONE;
              burst_cnt = '0;
            end else begin
              burst_cnt = COUNT_W_DEF'(sum);
            end
          end
          c.eob = (gate == PH_DONE);
          c.first = next_byte;
          next_byte = next_byte + BYTE_W'(len);
        end
      end
    endcase
    c.produced = PROD_W'(len);
    return c;
  endfunction

  always @(posedge clk) begin
    chunk_t want;
    if (rst) begin
      total_samples = SAMP_RST;
      pkt_len = PLEN_RST;
      gate = PH_IDLE;
      burst_cnt = '0;
      next_byte = '0;
      chunks_due.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_BURST: total_samples = pwdata[SAMP_W-1:0];
          REG_PLEN:  pkt_len = pwdata[PLEN_W-1:0];
          default: ;
        endcase
      end
      // request word in
      if (req.valid && req.ready)
        chunks_due.push_back(next_chunk(req_kind_t'(req.req_type), req.space));
      // result word out
      if (res.valid && res.ready) begin
        if (chunks_due.size() == 0) begin
          report_mismatch("unrequested result word", 1, 0);
        end else begin
          want = chunks_due.pop_front();
          if (res.produced !== want.produced)
            report_mismatch("produced", res.produced, want.produced);
          if (res.start_of_burst !== want.sob)
            report_mismatch("start_of_burst", res.start_of_burst, want.sob);
          if (res.end_of_burst !== want.eob)
            report_mismatch("end_of_burst", res.end_of_burst, want.eob);
          if (res.first_byte !== want.first)
            report_mismatch("first_byte", res.first_byte, want.first);
          if (res.msg_error !== want.err)
            report_mismatch("msg_error", res.msg_error, want.err);
        end
      end
    end
    outstanding <= chunks_due.size();
  end

endmodule

[tb/sv/tdd_burst_source_gate_test.sv]
// Stimulus and verdict for the burst source gate; prediction lives in the
// checker instantiated beside the block.
module tdd_burst_source_gate_test import tbsg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int chunks_pending;

  bit calm;
  bit rx_hold_req;
  int words_sent;
  int n_switch;
  int n_stop;
  int n_unknown;
  int n_settings;
  int cur_total;
  int idle_cycles;

  tbsg_req_if req ();
  tbsg_res_if res ();

  tdd_burst_source_gate uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tbsg_chunk_checker chunk_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (chunks_pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // per-word wait, none during calm stretches
  function automatic int draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 14));
  endfunction

  // watchdog: cycles with no word moved on any port
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCH_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = draw_wait();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  // one request word; valid stays high until the next gap
  task automatic send_word(req_kind_t kind, logic [SPACE_W-1:0] space);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.space <= space;
    do @(posedge clk); while (!req.ready);
    words_sent++;
    case (kind)
      REQ_SWITCH:  n_switch++;
      REQ_STOP:    n_stop++;
      REQ_UNKNOWN: n_unknown++;
      default: ;
    endcase
  endtask

  // sender idles until every expected result word is back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (chunks_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int total, int plen);
    reg_write(REG_BURST, APB_DW'(total));
    reg_write(REG_PLEN, APB_DW'(plen));
    cur_total = total;
    n_settings++;
  endtask

  // mostly whole bursts (two switches, chunks up to the total, now and then
  // a stop), with some stray words mixed in
  task automatic burst_traffic(int n);
    int              start;
    int              reqs;
    int              hi;
    longint          est;
    logic [SPACE_W-1:0] sp;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(req_kind_t'($urandom_range(0, 3)), SPACE_W'($urandom));
      end else begin
        send_word(REQ_SWITCH, SPACE_W'($urandom));
        send_word(REQ_SWITCH, SPACE_W'($urandom));
        hi = (2 * cur_total) / int'($urandom_range(1, 6));
        if (hi > 65535) hi = 65535;
        if (hi < 1) hi = 1;
        est = 0;
        reqs = 0;
        while (est < cur_total && reqs < 12) begin
          sp = SPACE_W'($urandom_range(0, hi));
          send_word(REQ_OUTPUT, sp);
          est += sp;
          reqs++;
          if ($urandom_range(0, 15) == 0) begin
            send_word(REQ_STOP, SPACE_W'($urandom));
            send_word(REQ_OUTPUT, SPACE_W'($urandom));
            est = cur_total;
          end
        end
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_OUTPUT;
    req.space = '0;
    res.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    rx_hold_req = 1'b0;
    cur_total = 1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, 1000 samples and 64-byte packets
    send_word(REQ_OUTPUT, 16'd100);     // gated while idle
    send_word(REQ_UNKNOWN, 16'hFFFF);
    send_word(REQ_STOP, 16'h0000);      // no effect while idle
    send_word(REQ_SWITCH, 16'h0000);
    send_word(REQ_OUTPUT, 16'd0);       // empty start chunk
    send_word(REQ_OUTPUT, 16'd0);       // still a start
    send_word(REQ_OUTPUT, 16'd300);
    send_word(REQ_OUTPUT, 16'hFFFF);    // final chunk, padded
    send_word(REQ_OUTPUT, 16'd5);       // gated while done
    send_word(REQ_SWITCH, 16'h5555);    // done back to idle
    send_word(REQ_OUTPUT, 16'd7);
    send_word(REQ_SWITCH, 16'hAAAA);
    send_word(REQ_STOP, 16'd0);
    send_word(REQ_SWITCH, 16'd0);       // ignored while stopping
    send_word(REQ_UNKNOWN, 16'd0);
    send_word(REQ_OUTPUT, 16'd9);       // stop chunk
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_OUTPUT, 16'd936);
    send_word(REQ_OUTPUT, 16'd64);      // aligned end: a whole extra packet
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_OUTPUT, 16'd900);
    drain();

    // total lowered under the running count
    reg_write(REG_BURST, APB_DW'(500));
    cur_total = 500;
    n_settings++;
    send_word(REQ_OUTPUT, 16'd10);
    drain();

    // zero packet length: no padding, empty stop chunk
    set_regs(50, 0);
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_OUTPUT, 16'd30);
    send_word(REQ_OUTPUT, 16'd30);
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_SWITCH, 16'd0);
    send_word(REQ_STOP, 16'd0);
    send_word(REQ_OUTPUT, 16'd1);
    drain();

    // extremes of both registers
    set_regs(1, 1);
    burst_traffic(150);
    drain();
    set_regs(24'hFFFFFF, 16'hFFFF);
    burst_traffic(40);
    drain();

    // result side held off while the sender keeps offering words
    set_regs(300, 32);
    calm = 1'b1;
    rx_hold_req = 1'b1;
    burst_traffic(200);
    calm = 1'b0;
    drain();

    // random settings, mostly short bursts
    repeat (8) begin
      if ($urandom_range(0, 4) == 0)
        set_regs($urandom_range(1, 200000), $urandom_range(0, 65535));
      else
        set_regs($urandom_range(1, 3000), $urandom_range(1, 512));
      calm = ($urandom_range(0, 3) == 0);
      burst_traffic(75);
      drain();
      burst_traffic(75);
      drain();
    end
    calm = 1'b0;

    $display("covered %0d request words (%0d switch, %0d stop, %0d unknown) over %0d settings",
             words_sent, n_switch, n_stop, n_unknown, n_settings);
    $display("incl. zero and full packet lengths, 1 and 2^24-1 totals, a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
